// ===== rtl/core/utf8d_pkg.sv =====
`default_nettype none

package utf8d_pkg;

    // Field widths
    localparam int unsigned CpWidth     = 21;
    localparam int unsigned StatusWidth = 3;
    localparam int unsigned LenWidth    = 3;
    localparam int unsigned ByteWidth   = 8;

    // Result status codes
    localparam logic [StatusWidth-1:0] ST_PENDING = 3'd0;
    localparam logic [StatusWidth-1:0] ST_CHAR    = 3'd1;
    localparam logic [StatusWidth-1:0] ST_NULL    = 3'd2;
    localparam logic [StatusWidth-1:0] ST_ILLEGAL = 3'd3;
    localparam logic [StatusWidth-1:0] ST_RESET   = 3'd4;

    // Input command codes
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    // Mode register reset value: UTF-8 decoding
    localparam logic MODE_RESET = 1'b1;

    // Scalar value limits
    localparam logic [CpWidth-1:0] CP_MAX        = 21'h10ffff;
    localparam logic [CpWidth-1:0] SURR_LO       = 21'h00d800;
    localparam logic [CpWidth-1:0] SURR_HI       = 21'h00dfff;
    localparam logic [CpWidth-1:0] MIN_TWO_BYTE  = 21'h000080;
    localparam logic [CpWidth-1:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [CpWidth-1:0] MIN_FOUR_BYTE = 21'h010000;

    // Lead byte ranges
    localparam logic [ByteWidth-1:0] LEAD2_LO = 8'hc2;
    localparam logic [ByteWidth-1:0] LEAD2_HI = 8'hdf;
    localparam logic [ByteWidth-1:0] LEAD3_LO = 8'he0;
    localparam logic [ByteWidth-1:0] LEAD3_HI = 8'hef;
    localparam logic [ByteWidth-1:0] LEAD4_LO = 8'hf0;
    localparam logic [ByteWidth-1:0] LEAD4_HI = 8'hf4;

    typedef struct packed {
        logic [1:0]         bytes_left;
        logic [LenWidth-1:0] seq_total;
        logic [CpWidth-1:0] accumulator;
    } t_state;

    typedef struct packed {
        logic [LenWidth-1:0]    seq_length;
        logic [StatusWidth-1:0] status;
        logic [CpWidth-1:0]     code_point;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/utf8d_step.sv =====
`default_nettype none

// One decode step: current shift state plus one word in, next state and result out.
module utf8d_step (
    input  wire logic                                 i_mode,
    input  wire logic                                 i_cmd,
    input  wire logic [utf8d_pkg::ByteWidth-1:0]      i_byte,
    input  wire utf8d_pkg::t_state                    i_state,
    output utf8d_pkg::t_state                         o_state,
    output utf8d_pkg::t_result                        o_result
);

    logic [utf8d_pkg::CpWidth-1:0]  v;
    logic [1:0]                     left;
    logic [utf8d_pkg::CpWidth-1:0]  least;
    logic                           scalar_ok;

    // Shift in six payload bits of a continuation byte
    assign v    = {i_state.accumulator[utf8d_pkg::CpWidth-7:0], i_byte[5:0]};
    assign left = i_state.bytes_left - 2'd1;

    always_comb begin
        unique case (i_state.seq_total)
            3'd2:    least = utf8d_pkg::MIN_TWO_BYTE;
            3'd3:    least = utf8d_pkg::MIN_THREE_BYTE;
            default: least = utf8d_pkg::MIN_FOUR_BYTE;
        endcase
    end

    assign scalar_ok = (v >= least) && (v <= utf8d_pkg::CP_MAX)
                    && !((v >= utf8d_pkg::SURR_LO) && (v <= utf8d_pkg::SURR_HI));

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.status = utf8d_pkg::ST_PENDING;
        if (i_cmd == utf8d_pkg::CMD_RESET) begin
            o_state = '0;
            o_result.status = utf8d_pkg::ST_RESET;
        end else if (!i_mode) begin
            // Single-byte locale: any leftover sequence is an error
            if (i_state != '0) begin
                o_state = '0;
                o_result.status = utf8d_pkg::ST_ILLEGAL;
            end else if (i_byte[7]) begin
                o_result.status = utf8d_pkg::ST_ILLEGAL;
            end else if (i_byte == '0) begin
                o_result.status     = utf8d_pkg::ST_NULL;
                o_result.seq_length = 3'd1;
            end else begin
                o_result.status     = utf8d_pkg::ST_CHAR;
                o_result.code_point = {13'd0, i_byte};
                o_result.seq_length = 3'd1;
            end
        end else if (i_state.bytes_left == 2'd0) begin
            if (i_byte == '0) begin
                o_state = '0;
                o_result.status     = utf8d_pkg::ST_NULL;
                o_result.seq_length = 3'd1;
            end else if (!i_byte[7]) begin
                o_result.status     = utf8d_pkg::ST_CHAR;
                o_result.code_point = {13'd0, i_byte};
                o_result.seq_length = 3'd1;
            end else if (i_byte >= utf8d_pkg::LEAD2_LO && i_byte <= utf8d_pkg::LEAD2_HI) begin
                o_state.seq_total   = 3'd2;
                o_state.bytes_left  = 2'd1;
                o_state.accumulator = {16'd0, i_byte[4:0]};
            end else if (i_byte >= utf8d_pkg::LEAD3_LO && i_byte <= utf8d_pkg::LEAD3_HI) begin
                o_state.seq_total   = 3'd3;
                o_state.bytes_left  = 2'd2;
                o_state.accumulator = {17'd0, i_byte[3:0]};
            end else if (i_byte >= utf8d_pkg::LEAD4_LO && i_byte <= utf8d_pkg::LEAD4_HI) begin
                o_state.seq_total   = 3'd4;
                o_state.bytes_left  = 2'd3;
                o_state.accumulator = {18'd0, i_byte[2:0]};
            end else begin
                o_state = '0;
                o_result.status = utf8d_pkg::ST_ILLEGAL;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            // Bad continuation: drop the byte and the open sequence
            o_state = '0;
            o_result.status = utf8d_pkg::ST_ILLEGAL;
        end else if (left != 2'd0) begin
            o_state.bytes_left  = left;
            o_state.accumulator = v;
        end else begin
            o_state = '0;
            if (scalar_ok) begin
                o_result.status     = utf8d_pkg::ST_CHAR;
                o_result.code_point = v;
                o_result.seq_length = i_state.seq_total;
            end else begin
                o_result.status = utf8d_pkg::ST_ILLEGAL;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder_top.sv =====
// Channel   | Direction | tdata (low bit up)                    | tuser
// ----------+-----------+---------------------------------------+--------------
// s_axis    | in        | [7:0] data_byte                       | [0] command
// m_axis    | out       | [20:0] code_point, [23:21] seq_length | [2:0] status
// cfg       | in        | i_cfg_wdata = utf8_mode               | -
//
// One result word per input word; an accepted word goes from the input register
// through the decode step into the result register, and one word a cycle is
// sustained on this path while i_m_axis_tready does not stall the result register.
// Reset (i_rst_n low, synchronous) clears the shift state, empties both
// registers and sets utf8_mode to UTF-8 decoding.
// A stalled result register holds its word; the input register then holds
// too, and o_s_axis_tready drops once the input register is full.
`default_nettype none

module utf8_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,      // utf8_mode
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] command
    // Result stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [23:0] o_m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
    output      logic [2:0]  o_m_axis_tuser    // [2:0] status
);

    // Mode register
    logic r_mode;

    // Input register
    logic                               r_in_valid;
    logic                               r_in_cmd;
    logic [utf8d_pkg::ByteWidth-1:0]    r_in_byte;

    // Shift state
    utf8d_pkg::t_state  r_state;
    utf8d_pkg::t_state  n_state;

    // Result register
    logic               r_out_valid;
    utf8d_pkg::t_result r_out;
    utf8d_pkg::t_result n_out;

    logic in_accept;
    logic advance;

    // Move the held word into the result register when that slot frees up
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= utf8d_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: capture on accept, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    utf8d_step u_step (
        .i_mode   (r_mode),
        .i_cmd    (r_in_cmd),
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Advance the shift state only when the word really moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.seq_length, r_out.code_point};
    assign o_m_axis_tuser  = r_out.status;

`ifndef ASSERT_OFF
    // An open sequence always has fewer bytes left than its total length
    a_state_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bytes_left != 2'd0) |-> (r_state.seq_total > {1'b0, r_state.bytes_left}))
        else $error("shift state inconsistent");

    // A reported character is a valid scalar value
    a_char_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == utf8d_pkg::ST_CHAR) |->
        ((r_out.code_point <= utf8d_pkg::CP_MAX) &&
         !((r_out.code_point >= utf8d_pkg::SURR_LO) &&
           (r_out.code_point <= utf8d_pkg::SURR_HI))))
        else $error("character result outside scalar range");

    // Only character results carry a value
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != utf8d_pkg::ST_CHAR) |-> (r_out.code_point == '0))
        else $error("non-character result carries a code point");

    // A reset command leaves the shift state empty
    a_cmd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_cmd == utf8d_pkg::CMD_RESET) |=> (r_state == '0))
        else $error("reset command left shift state");
`endif

endmodule

`default_nettype wire
